// ===== sv/scr_pkg.sv =====
// Shared types, widths and register codes for the two-channel sensor
// calibration block. No dependencies; every other file imports this package.
package scr_pkg;

   localparam int RAW_W       = 16;
   localparam int RND_W       = 16;
   localparam int CFG_W       = 16;
   localparam int CAL_W       = 32;
   localparam int CSR_INDEX_W = 8;

   localparam int SUM_W       = 23;
   localparam int U_W         = SUM_W - 3;
   localparam int MAG_W       = 18;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 20;
   localparam int Q_W         = 15;
   localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(104857);

   localparam int DIFF_W      = CFG_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int NUM_W       = PROD_W + 1;
   localparam int DIVIDEND_W  = NUM_W - 2;
   localparam int DIVISOR_W   = CFG_W;
   localparam int QS_W        = DIVIDEND_W + 1;
   localparam int DIV_STAGES  = DIVIDEND_W;

   localparam int ROUND_STAGES = 3;
   localparam int CAL_STAGES   = DIV_STAGES + 3;
   localparam int PIPE_DEPTH   = ROUND_STAGES + CAL_STAGES;

   localparam logic signed [CAL_W-1:0] ZERO_SPAN_VALUE = -CAL_W'(10);
   localparam logic signed [CAL_W-1:0] CAL_MAX = {1'b0, {(CAL_W-1){1'b1}}};
   localparam logic signed [CAL_W-1:0] CAL_MIN = {1'b1, {(CAL_W-1){1'b0}}};

   localparam logic signed [CFG_W-1:0] IN_LOW_RESET   = CFG_W'(0);
   localparam logic signed [CFG_W-1:0] IN_HIGH_RESET  = CFG_W'(1000);
   localparam logic signed [CFG_W-1:0] OUT_LOW_RESET  = CFG_W'(0);
   localparam logic signed [CFG_W-1:0] OUT_HIGH_RESET = CFG_W'(1000);

   localparam logic [CSR_INDEX_W-1:0] REG_IN_LOW_A   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IN_HIGH_A  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_LOW_A  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_HIGH_A = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_IN_LOW_B   = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_IN_HIGH_B  = CSR_INDEX_W'(5);
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_LOW_B  = CSR_INDEX_W'(6);
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_HIGH_B = CSR_INDEX_W'(7);

   typedef struct packed {
      logic signed [CFG_W-1:0] in_low;
      logic signed [CFG_W-1:0] in_high;
      logic signed [CFG_W-1:0] out_low;
      logic signed [CFG_W-1:0] out_high;
   } scr_cal_type;

   typedef struct packed {
      logic                    neg;
      logic                    span_zero;
      logic signed [RND_W-1:0] rounded;
   } scr_side_type;

   typedef struct packed {
      logic signed [RAW_W-1:0] reading_a;
      logic signed [RAW_W-1:0] reading_b;
   } scr_req_type;

   typedef struct packed {
      logic signed [RND_W-1:0] rounded_a;
      logic signed [RND_W-1:0] rounded_b;
      logic signed [CAL_W-1:0] calibrated_a;
      logic signed [CAL_W-1:0] calibrated_b;
      logic                    span_zero_a;
      logic                    span_zero_b;
   } scr_rsp_type;

endpackage

// ===== sv/sensor_reading_two_point_calibrate.sv =====
// Top level of the two-channel sensor calibration block: configuration
// registers, two lanes of scr_round and scr_cal, and the merged output stage.
// Depends on scr_pkg, scr_round and scr_cal.
//
// The block takes one word of two raw sensor readings per cycle while
// req_ready is high and returns one result word for each, in order. Each
// word passes three rounding stages, a product stage, a numerator stage, a
// 33-stage divider (one quotient bit per stage) and a saturation stage in
// each lane, then the output register. A skid register behind the output
// lets one more word drain from the pipeline while the result side stalls;
// after that req_ready drops until the skid register empties. Calibration
// registers are written through the csr_ port, which is always ready;
// indexes beyond 7 are ignored. Write them only while no word is in flight.
module sensor_reading_two_point_calibrate import scr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  scr_req_type            req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output scr_rsp_type            rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_word
);

   scr_cal_type             cal_a_ff;
   scr_cal_type             cal_b_ff;
   logic [PIPE_DEPTH-1:0]   valid_ff;
   logic                    en;
   logic                    pipe_valid;
   logic signed [RND_W-1:0] rnd_a;
   logic signed [RND_W-1:0] rnd_b;
   scr_rsp_type             pipe_word;
   logic                    rsp_valid_ff;
   scr_rsp_type             rsp_word_ff;
   logic                    skid_valid_ff;
   scr_rsp_type             skid_word_ff;

   assign csr_ready  = 1'b1;
   assign en         = !skid_valid_ff;
   assign req_ready  = en;
   assign pipe_valid = valid_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '{IN_LOW_RESET, IN_HIGH_RESET, OUT_LOW_RESET, OUT_HIGH_RESET};
         cal_b_ff <= '{IN_LOW_RESET, IN_HIGH_RESET, OUT_LOW_RESET, OUT_HIGH_RESET};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IN_LOW_A:   cal_a_ff.in_low   <= csr_word;
            REG_IN_HIGH_A:  cal_a_ff.in_high  <= csr_word;
            REG_OUT_LOW_A:  cal_a_ff.out_low  <= csr_word;
            REG_OUT_HIGH_A: cal_a_ff.out_high <= csr_word;
            REG_IN_LOW_B:   cal_b_ff.in_low   <= csr_word;
            REG_IN_HIGH_B:  cal_b_ff.in_high  <= csr_word;
            REG_OUT_LOW_B:  cal_b_ff.out_low  <= csr_word;
            REG_OUT_HIGH_B: cal_b_ff.out_high <= csr_word;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   scr_round u_round_a (
      .clock   (clock),
      .en      (en),
      .raw     (req_word.reading_a),
      .rounded (rnd_a)
   );

   scr_round u_round_b (
      .clock   (clock),
      .en      (en),
      .raw     (req_word.reading_b),
      .rounded (rnd_b)
   );

   scr_cal u_cal_a (
      .clock       (clock),
      .en          (en),
      .cal         (cal_a_ff),
      .rounded     (rnd_a),
      .rounded_out (pipe_word.rounded_a),
      .calibrated  (pipe_word.calibrated_a),
      .span_zero   (pipe_word.span_zero_a)
   );

   scr_cal u_cal_b (
      .clock       (clock),
      .en          (en),
      .cal         (cal_b_ff),
      .rounded     (rnd_b),
      .rounded_out (pipe_word.rounded_b),
      .calibrated  (pipe_word.calibrated_b),
      .span_zero   (pipe_word.span_zero_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         if (pipe_valid) begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (rsp_ready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (pipe_valid) begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_word_ff <= pipe_word;
            end else begin
               skid_word_ff <= pipe_word;
            end
         end
      end else if (rsp_ready) begin
         rsp_word_ff <= skid_word_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a word while the output register is empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (en && pipe_valid && rsp_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("word leaving the pipeline was not caught by the skid register");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (!en && rsp_ready) |=> (!skid_valid_ff && rsp_valid_ff))
      else $error("skid register did not move into the output register");

   a_zero_span_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.span_zero_a || rsp_word_ff.span_zero_b)) |->
      ((!rsp_word_ff.span_zero_a || rsp_word_ff.calibrated_a == ZERO_SPAN_VALUE) &&
       (!rsp_word_ff.span_zero_b || rsp_word_ff.calibrated_b == ZERO_SPAN_VALUE)))
      else $error("zero span flag without the forced calibrated value");
`endif

endmodule

// ===== sv/scr_round.sv =====
// One lane of raw-word rounding: 1/16 degree units to tenths, three stages.
// Depends on scr_pkg.
module scr_round import scr_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [RAW_W-1:0] raw,
   output logic signed [RND_W-1:0] rounded
);

   logic signed [SUM_W-1:0]       raw_x;
   logic signed [SUM_W-1:0]       sum;
   logic signed [SUM_W-1:0]       adj;
   logic signed [U_W-1:0]         u;
   logic [U_W-1:0]                u_abs;
   logic [MAG_W-1:0]              m1_in;
   logic [MAG_W-1:0]              m1_ff;
   logic                          neg1_ff;
   logic [MAG_W+RECIP_W-1:0]      prod;
   logic [Q_W-1:0]                q2_in;
   logic [Q_W-1:0]                q2_ff;
   logic [MAG_W-1:0]              m2_ff;
   logic                          neg2_ff;
   logic [MAG_W-1:0]              rem_full;
   logic [4:0]                    rem5;
   logic                          ge10;
   logic [4:0]                    remc;
   logic [RND_W-1:0]              qc;
   logic [RND_W-1:0]              qr;
   logic signed [RND_W-1:0]       rounded_in;
   logic signed [RND_W-1:0]       rounded_ff;

   always_comb begin
      raw_x = SUM_W'(raw);
      sum   = (raw_x <<< 5) + (raw_x <<< 4) + (raw_x <<< 1) + SUM_W'(25);
      adj   = sum[SUM_W-1] ? sum + SUM_W'(7) : sum;
      u     = adj[SUM_W-1:3];
      u_abs = u[U_W-1] ? -u : u;
      m1_in = u_abs[MAG_W-1:0];
   end

   assign prod  = (MAG_W+RECIP_W)'(m1_ff) * (MAG_W+RECIP_W)'(RECIP_TEN);
   assign q2_in = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

   always_comb begin
      rem_full   = m2_ff - (MAG_W'(q2_ff) << 3) - (MAG_W'(q2_ff) << 1);
      rem5       = rem_full[4:0];
      ge10       = rem5 >= 5'd10;
      qc         = RND_W'(q2_ff) + RND_W'(ge10);
      remc       = ge10 ? rem5 - 5'd10 : rem5;
      qr         = qc + RND_W'(!neg2_ff && (remc >= 5'd5));
      rounded_in = neg2_ff ? -qr : qr;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff      <= m1_in;
         neg1_ff    <= u[U_W-1];
         q2_ff      <= q2_in;
         m2_ff      <= m1_ff;
         neg2_ff    <= neg1_ff;
         rounded_ff <= rounded_in;
      end
   end

   assign rounded = rounded_ff;

endmodule

// ===== sv/scr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side-band
// carried alongside. Depends on scr_pkg.
module scr_div import scr_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   input  scr_side_type          side_in,
   output logic [DIVIDEND_W-1:0] quotient,
   output scr_side_type          side_out
);

   logic [DIVISOR_W:0]    trial   [DIV_STAGES];
   logic [DIVISOR_W:0]    diff    [DIV_STAGES-1];
   logic                  ge      [DIV_STAGES];
   logic [DIVIDEND_W-1:0] dq_src  [DIV_STAGES];
   scr_side_type          side_src[DIV_STAGES];
   logic [DIVISOR_W-1:0]  rem_in  [DIV_STAGES-1];
   logic [DIVIDEND_W-1:0] dq_in   [DIV_STAGES];
   logic [DIVISOR_W-1:0]  rem_ff  [DIV_STAGES-1];
   logic [DIVIDEND_W-1:0] dq_ff   [DIV_STAGES];
   scr_side_type          side_ff [DIV_STAGES];

   always_comb begin
      trial[0]    = {{DIVISOR_W{1'b0}}, dividend[DIVIDEND_W-1]};
      dq_src[0]   = dividend;
      side_src[0] = side_in;
      for (int k = 1; k < DIV_STAGES; k++) begin
         trial[k]    = {rem_ff[k-1], dq_ff[k-1][DIVIDEND_W-1]};
         dq_src[k]   = dq_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         ge[k]    = trial[k] >= {1'b0, divisor};
         dq_in[k] = {dq_src[k][DIVIDEND_W-2:0], ge[k]};
      end
      for (int k = 0; k < DIV_STAGES - 1; k++) begin
         diff[k]   = trial[k] - {1'b0, divisor};
         rem_in[k] = ge[k] ? diff[k][DIVISOR_W-1:0] : trial[k][DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            dq_ff[k]   <= dq_in[k];
            side_ff[k] <= side_src[k];
         end
         for (int k = 0; k < DIV_STAGES - 1; k++) begin
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   assign quotient = dq_ff[DIV_STAGES-1];
   assign side_out = side_ff[DIV_STAGES-1];

endmodule

// ===== sv/scr_cal.sv =====
// One lane of two-point linear calibration: products, numerator, divider,
// sign, zero-span value and saturation. Depends on scr_pkg and scr_div.
module scr_cal import scr_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  scr_cal_type             cal,
   input  logic signed [RND_W-1:0] rounded,
   output logic signed [RND_W-1:0] rounded_out,
   output logic signed [CAL_W-1:0] calibrated,
   output logic                    span_zero
);

   logic signed [DIFF_W-1:0]  span;
   logic signed [DIFF_W-1:0]  gain;
   logic signed [DIFF_W-1:0]  diff;
   logic [DIFF_W-1:0]         span_abs;
   logic [DIVISOR_W-1:0]      span_mag;
   logic signed [PROD_W-1:0]  p1_in;
   logic signed [PROD_W-1:0]  p2_in;
   logic signed [PROD_W-1:0]  p1_ff;
   logic signed [PROD_W-1:0]  p2_ff;
   logic signed [RND_W-1:0]   rnd_p_ff;
   logic signed [NUM_W-1:0]   num;
   logic [NUM_W-1:0]          num_abs;
   logic [DIVIDEND_W-1:0]     nmag_ff;
   scr_side_type              side_n_in;
   scr_side_type              side_n_ff;
   logic [DIVIDEND_W-1:0]     quotient;
   scr_side_type              side_q;
   logic signed [QS_W-1:0]    qs;
   logic signed [QS_W-1:0]    qv;
   logic                      sat_hi;
   logic                      sat_lo;
   logic signed [CAL_W-1:0]   cal_in;
   logic signed [CAL_W-1:0]   cal_ff;
   logic                      zero_ff;
   logic signed [RND_W-1:0]   rnd_f_ff;

   always_comb begin
      span     = DIFF_W'(cal.in_high) - DIFF_W'(cal.in_low);
      gain     = DIFF_W'(cal.out_high) - DIFF_W'(cal.out_low);
      diff     = DIFF_W'(rounded) - DIFF_W'(cal.in_low);
      span_abs = span[DIFF_W-1] ? -span : span;
      span_mag = span_abs[DIVISOR_W-1:0];
      p1_in    = PROD_W'(cal.out_low) * PROD_W'(span);
      p2_in    = PROD_W'(diff) * PROD_W'(gain);
   end

   always_comb begin
      num                 = NUM_W'(p1_ff) + NUM_W'(p2_ff);
      num_abs             = num[NUM_W-1] ? -num : num;
      side_n_in.neg       = num[NUM_W-1] ^ span[DIFF_W-1];
      side_n_in.span_zero = span == '0;
      side_n_in.rounded   = rnd_p_ff;
   end

   scr_div u_div (
      .clock    (clock),
      .en       (en),
      .dividend (nmag_ff),
      .divisor  (span_mag),
      .side_in  (side_n_ff),
      .quotient (quotient),
      .side_out (side_q)
   );

   always_comb begin
      qs     = QS_W'(quotient);
      qv     = side_q.neg ? -qs : qs;
      sat_hi = !qv[QS_W-1] && (qv[QS_W-2:CAL_W-1] != '0);
      sat_lo = qv[QS_W-1] && (qv[QS_W-2:CAL_W-1] != '1);
      priority if (side_q.span_zero) begin
         cal_in = ZERO_SPAN_VALUE;
      end else if (sat_hi) begin
         cal_in = CAL_MAX;
      end else if (sat_lo) begin
         cal_in = CAL_MIN;
      end else begin
         cal_in = qv[CAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         rnd_p_ff  <= rounded;
         nmag_ff   <= num_abs[DIVIDEND_W-1:0];
         side_n_ff <= side_n_in;
         cal_ff    <= cal_in;
         zero_ff   <= side_q.span_zero;
         rnd_f_ff  <= side_q.rounded;
      end
   end

   assign rounded_out = rnd_f_ff;
   assign calibrated  = cal_ff;
   assign span_zero   = zero_ff;

endmodule

// ===== dv/scr_checker.sv =====
// Checker for the two-channel sensor calibration block: watches the req_, rsp_ and
// csr_ channels, keeps its own calibration copy and predicts each result word.
// Depends on scr_pkg.
module scr_checker import scr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  scr_req_type            req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  scr_rsp_type            rsp_word,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_word,
   output int                     fail_count,
   output int                     pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   scr_cal_type cal_a;
   scr_cal_type cal_b;
   scr_rsp_type expected_pairs[$];

   function automatic logic signed [RND_W-1:0] round_to_tenths(
      input logic signed [RAW_W-1:0] raw
   );
      longint u;
      u = (longint'(raw) * 50 + 25) / 8;
      if (u % 10 >= 5) begin
         u = u + 10;
      end
      return RND_W'(u / 10);
   endfunction

   function automatic logic signed [CAL_W-1:0] calibrate_tenths(
      input  longint      reading,
      input  scr_cal_type c,
      output logic        zero
   );
      longint span;
      longint q;
      span = longint'(c.in_high) - longint'(c.in_low);
      zero = (span == 0);
      if (zero) begin
         return ZERO_SPAN_VALUE;
      end
      q = (longint'(c.out_low) * span
           + (reading - longint'(c.in_low)) * (longint'(c.out_high) - longint'(c.out_low)))
          / span;
      if (q > longint'(CAL_MAX)) begin
         q = longint'(CAL_MAX);
      end
      if (q < longint'(CAL_MIN)) begin
         q = longint'(CAL_MIN);
      end
      return CAL_W'(q);
   endfunction

   function automatic scr_rsp_type predict_reading_pair(input scr_req_type w);
      scr_rsp_type p;
      logic        za;
      logic        zb;
      p.rounded_a    = round_to_tenths(w.reading_a);
      p.rounded_b    = round_to_tenths(w.reading_b);
      p.calibrated_a = calibrate_tenths(longint'(p.rounded_a), cal_a, za);
      p.calibrated_b = calibrate_tenths(longint'(p.rounded_b), cal_b, zb);
      p.span_zero_a  = za;
      p.span_zero_b  = zb;
      return p;
   endfunction

   always @(posedge clock) begin
      scr_rsp_type want;
      if (reset) begin
         cal_a = '{in_low: IN_LOW_RESET, in_high: IN_HIGH_RESET,
                   out_low: OUT_LOW_RESET, out_high: OUT_HIGH_RESET};
         cal_b = cal_a;
         expected_pairs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IN_LOW_A:   cal_a.in_low   = csr_word;
               REG_IN_HIGH_A:  cal_a.in_high  = csr_word;
               REG_OUT_LOW_A:  cal_a.out_low  = csr_word;
               REG_OUT_HIGH_A: cal_a.out_high = csr_word;
               REG_IN_LOW_B:   cal_b.in_low   = csr_word;
               REG_IN_HIGH_B:  cal_b.in_high  = csr_word;
               REG_OUT_LOW_B:  cal_b.out_low  = csr_word;
               REG_OUT_HIGH_B: cal_b.out_high = csr_word;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_pairs.push_back(predict_reading_pair(req_word));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               if (fail_count < 10) begin
                  $display("[%0t] unexpected result word: ra=%0d rb=%0d ca=%0d cb=%0d za=%0b zb=%0b",
                           $realtime, rsp_word.rounded_a, rsp_word.rounded_b,
                           rsp_word.calibrated_a, rsp_word.calibrated_b,
                           rsp_word.span_zero_a, rsp_word.span_zero_b);
               end
               fail_count++;
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_word !== want) begin
                  if (fail_count < 10) begin
                     $display("[%0t] mismatch, expected: ra=%0d rb=%0d ca=%0d cb=%0d za=%0b zb=%0b",
                              $realtime, want.rounded_a, want.rounded_b, want.calibrated_a,
                              want.calibrated_b, want.span_zero_a, want.span_zero_b);
                     $display("             actual:   ra=%0d rb=%0d ca=%0d cb=%0d za=%0b zb=%0b",
                              rsp_word.rounded_a, rsp_word.rounded_b, rsp_word.calibrated_a,
                              rsp_word.calibrated_b, rsp_word.span_zero_a, rsp_word.span_zero_b);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending_words = expected_pairs.size();
   end

endmodule

// ===== dv/sensor_reading_two_point_calibrate_tb.sv =====
// Top of the sensor calibration testbench: clock, reset, stimulus and verdict.
// Drives sensor_reading_two_point_calibrate through directed and random phases,
// each with its own calibration; scr_checker does the prediction. Depends on scr_pkg.
module sensor_reading_two_point_calibrate_tb import scr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {DRAIN_FULL, DRAIN_COIN, DRAIN_SPARSE, DRAIN_PULSE} drain_mode_type;

   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_UNUSED = CSR_INDEX_W'(8);
   localparam int RANDOM_PHASES    = 8;
   localparam int WORDS_PER_PHASE  = 225;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   scr_req_type            req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   scr_rsp_type            rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_word = '0;
   int                     fail_count;
   int                     pending_words;

   drain_mode_type drain_mode = DRAIN_FULL;
   int             drain_left = 0;
   int             burst_left = 0;

   always #1 clock = ~clock;

   sensor_reading_two_point_calibrate i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_word  (csr_word)
   );

   scr_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_word      (csr_word),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always @(negedge clock) begin
      if (drain_left == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(0, 3));
         drain_left <= $urandom_range(16, 160);
      end else begin
         drain_left <= drain_left - 1;
      end
      case (drain_mode)
         DRAIN_FULL:   rsp_ready <= 1'b1;
         DRAIN_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         DRAIN_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         DRAIN_PULSE:  rsp_ready <= drain_left[3];
      endcase
   end

   function automatic scr_req_type make_pair(input int a, input int b);
      scr_req_type w;
      w.reading_a = RAW_W'(a);
      w.reading_b = RAW_W'(b);
      return w;
   endfunction

   function automatic scr_cal_type make_cal(input int il, input int ih, input int ol,
                                            input int oh);
      scr_cal_type c;
      c.in_low   = CFG_W'(il);
      c.in_high  = CFG_W'(ih);
      c.out_low  = CFG_W'(ol);
      c.out_high = CFG_W'(oh);
      return c;
   endfunction

   function automatic int rand_raw();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2, 3:    return int'($urandom_range(0, 3200)) - 1200;
         4:       return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 15))
                                              : -32768 + int'($urandom_range(0, 15));
         default: return int'($urandom_range(0, 64)) - 32;
      endcase
   endfunction

   function automatic scr_cal_type rand_cal();
      int il;
      int ol;
      il = int'($urandom_range(0, 400)) - 200;
      ol = int'($urandom_range(0, 400)) - 200;
      case ($urandom_range(0, 4))
         0:       return make_cal($urandom, $urandom, $urandom, $urandom);
         1:       return make_cal(il, il + int'($urandom_range(700, 1300)),
                                  ol, ol + int'($urandom_range(700, 1300)));
         2:       return make_cal(il, il, $urandom, $urandom);
         3:       return make_cal($urandom, $urandom, il, ol);
         default: return make_cal(-32768 + int'($urandom_range(0, 3)),
                                  -32768 + int'($urandom_range(4, 6)),
                                  $urandom_range(0, 1) ? -32768 : 32767,
                                  $urandom_range(0, 1) ? 32767 : -32768);
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic push_reading(input scr_req_type w);
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_word  <= CFG_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_cal(input scr_cal_type a, input scr_cal_type b);
      write_reg(REG_IN_LOW_A, int'(a.in_low));
      write_reg(REG_IN_HIGH_A, int'(a.in_high));
      write_reg(REG_OUT_LOW_A, int'(a.out_low));
      write_reg(REG_OUT_HIGH_A, int'(a.out_high));
      write_reg(REG_IN_LOW_B, int'(b.in_low));
      write_reg(REG_IN_HIGH_B, int'(b.in_high));
      write_reg(REG_OUT_LOW_B, int'(b.out_low));
      write_reg(REG_OUT_HIGH_B, int'(b.out_high));
      // drop: out-of-range index must not touch any register
      write_reg(CSR_INDEX_W'($urandom_range(int'(REG_FIRST_UNUSED), (1 << CSR_INDEX_W) - 1)),
                $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      push_reading(make_pair(-32768, 32767));
      push_reading(make_pair(32767, -32768));
      push_reading(make_pair(0, -1));
      push_reading(make_pair(1, -8));
      push_reading(make_pair(8, -9));
      push_reading(make_pair(-1, 1));
      push_reading(make_pair(21845, -21846));
      push_reading(make_pair(24, -24));
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      finish_phase();

      load_cal(make_cal(-32768, -32767, -32768, 32767), make_cal(-32768, -32767, 32767, -32768));
      run_directed();
      finish_phase();

      load_cal(make_cal(32767, 32767, 123, -456), make_cal(-32768, -32768, -32768, 32767));
      run_directed();
      finish_phase();

      load_cal(make_cal(32767, -32768, -32768, 32767), make_cal(-32768, 32767, 32767, -32768));
      repeat (WORDS_PER_PHASE / 4) push_reading(make_pair(rand_raw(), rand_raw()));
      finish_phase();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_cal(rand_cal(), rand_cal());
         repeat (WORDS_PER_PHASE) push_reading(make_pair(rand_raw(), rand_raw()));
         finish_phase();
      end

      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
